@@ rtl/selective_repeat_arq_control_macros.svh @@
`ifndef SELECTIVE_REPEAT_ARQ_CONTROL_MACROS_SVH
`define SELECTIVE_REPEAT_ARQ_CONTROL_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SRARQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srarq assertion failed");

// Next-cycle implication.
`define SRARQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srarq assertion failed");

`endif

@@ rtl/srarq_pkg.sv @@
package srarq_pkg;

  localparam int SEQ_W        = 3;
  localparam int SLOT_W       = 2;
  localparam int WINDOW_SLOTS = 1 << SLOT_W;
  localparam int CNT_W        = SLOT_W + 1;
  localparam int ITER_W       = SLOT_W + 1;
  localparam int TICK_W       = 16;
  localparam int ACT_W        = 3;
  localparam int OP_W         = 3;
  localparam int KIND_W       = 2;
  localparam int MAX_RESULTS  = 16;
  localparam int REC_W        = $clog2(MAX_RESULTS);
  localparam int CFG_IDX_W    = 2;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [TICK_W-1:0]    ACK_TICKS_RST  = TICK_W'(260);
  localparam logic [TICK_W-1:0]    DATA_TICKS_RST = TICK_W'(2000);
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TICKS  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_TICKS = CFG_IDX_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_NET_READY    = 3'd0,
    OP_PHYS_READY   = 3'd1,
    OP_FRAME        = 3'd2,
    OP_ACK_TIMEOUT  = 3'd3,
    OP_DATA_TIMEOUT = 3'd4
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA = 2'd0,
    KIND_ACK  = 2'd1,
    KIND_NAK  = 2'd2
  } frame_kind_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_STATUS          = 3'd0,
    ACT_SEND_DATA       = 3'd1,
    ACT_SEND_ACK        = 3'd2,
    ACT_SEND_NAK        = 3'd3,
    ACT_STORE           = 3'd4,
    ACT_DELIVER         = 3'd5,
    ACT_STOP_DATA_TIMER = 3'd6,
    ACT_START_ACK_TIMER = 3'd7
  } action_e;

  typedef enum logic [3:0] {
    CMD_NET,
    CMD_PHYS,
    CMD_BAD_FRAME,
    CMD_DATA_FRAME,
    CMD_NAK_FRAME,
    CMD_ACK_FRAME,
    CMD_ACK_TIMEOUT,
    CMD_DATA_TIMEOUT,
    CMD_NOP
  } cmd_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MAIN,
    B_STORE,
    B_DELIV,
    B_DTIMER,
    B_ACKS,
    B_STATUS
  } bstate_e;

  // seq carries the frame seq, or the timed-out seq for a data timeout
  typedef struct packed {
    cmd_e             cmd;
    logic [SEQ_W-1:0] seq;
    logic [SEQ_W-1:0] ack;
  } cmd_t;

  typedef struct packed {
    action_e           action;
    logic [SEQ_W-1:0]  seq;
    logic [SEQ_W-1:0]  ack;
    logic [SLOT_W-1:0] slot;
    logic [TICK_W-1:0] ticks;
    logic              en;
    logic              last;
  } rec_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] outstanding;
  } stat_t;

  // b in circular interval [a, c)
  function automatic logic in_window(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b,
                                     logic [SEQ_W-1:0] c);
    if (a <= c) begin
      return (a <= b) && (b < c);
    end
    return (a <= b) || (b < c);
  endfunction

endpackage

@@ rtl/srarq_front.sv @@
module srarq_front (
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [srarq_pkg::OP_W-1:0]    op_i,
  input  logic                          frame_good_i,
  input  logic [srarq_pkg::KIND_W-1:0]  frame_kind_i,
  input  logic [srarq_pkg::SEQ_W-1:0]   frame_seq_i,
  input  logic [srarq_pkg::SEQ_W-1:0]   peer_ack_i,
  input  logic [srarq_pkg::SEQ_W-1:0]   timeout_seq_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output srarq_pkg::cmd_t               q_data_o
);
  import srarq_pkg::*;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_data_o     = '0;
    q_data_o.seq = frame_seq_i;
    q_data_o.ack = peer_ack_i;
    case (op_e'(op_i))
      OP_NET_READY:   q_data_o.cmd = CMD_NET;
      OP_PHYS_READY:  q_data_o.cmd = CMD_PHYS;
      OP_FRAME: begin
        if (!frame_good_i) begin
          q_data_o.cmd = CMD_BAD_FRAME;
        end else begin
          case (frame_kind_e'(frame_kind_i))
            KIND_DATA: q_data_o.cmd = CMD_DATA_FRAME;
            KIND_NAK:  q_data_o.cmd = CMD_NAK_FRAME;
            default:   q_data_o.cmd = CMD_ACK_FRAME;
          endcase
        end
      end
      OP_ACK_TIMEOUT: q_data_o.cmd = CMD_ACK_TIMEOUT;
      OP_DATA_TIMEOUT: begin
        q_data_o.cmd = CMD_DATA_TIMEOUT;
        q_data_o.seq = timeout_seq_i;
      end
      default:        q_data_o.cmd = CMD_NOP;
    endcase
  end

endmodule

@@ rtl/srarq_queue.sv @@
module srarq_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  srarq_pkg::cmd_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output srarq_pkg::cmd_t data_o
);
  import srarq_pkg::*;

  cmd_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ rtl/srarq_back.sv @@
module srarq_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  input  srarq_pkg::cmd_t               q_data_i,
  output logic                          q_pop_o,
  input  logic [srarq_pkg::TICK_W-1:0]  ack_ticks_i,
  input  logic [srarq_pkg::TICK_W-1:0]  data_ticks_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output srarq_pkg::rec_t               rec_o,
  output srarq_pkg::stat_t              stat_o
);
  import srarq_pkg::*;

  bstate_e            state_q, state_d;
  cmd_t               cmd_q, cmd_d;
  logic [SEQ_W-1:0]   oldest_q, oldest_d;
  logic [SEQ_W-1:0]   next_q, next_d;
  logic [SEQ_W-1:0]   exp_q, exp_d;
  logic [SEQ_W-1:0]   rlim_q, rlim_d;
  logic [CNT_W-1:0]   out_cnt_q, out_cnt_d;
  logic               nak_ok_q, nak_ok_d;
  logic               phys_q, phys_d;
  logic [WINDOW_SLOTS-1:0] arrived_q, arrived_d;
  logic [ITER_W-1:0]  iter_q, iter_d;
  logic [REC_W-1:0]   rec_cnt_q, rec_cnt_d;
  logic               out_valid_q;
  rec_t               rec_q, rec_d;

  logic               out_free, emit, keep, load;
  logic               ack_hit, deliv_hit, store_hit;
  logic [SEQ_W-1:0]   last_acked, nak_seq;
  logic [SLOT_W-1:0]  fslot, eslot;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign last_acked = exp_q - 1'b1;
  assign nak_seq    = cmd_q.ack + 1'b1;
  assign fslot      = cmd_q.seq[SLOT_W-1:0];
  assign eslot      = exp_q[SLOT_W-1:0];
  assign ack_hit    = (out_cnt_q != '0) && in_window(oldest_q, cmd_q.ack, next_q);
  assign deliv_hit  = (iter_q < ITER_W'(WINDOW_SLOTS)) && arrived_q[eslot];
  assign store_hit  = in_window(exp_q, cmd_q.seq, rlim_q) && !arrived_q[fslot];
  // action records past the per-event limit are dropped; status always goes out
  assign keep       = rec_d.last || (rec_cnt_q < REC_W'(MAX_RESULTS - 1));
  assign load       = emit && keep;

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) state_d = B_MAIN;
      end
      B_MAIN: begin
        if (out_free) begin
          case (cmd_q.cmd)
            CMD_DATA_FRAME: state_d = B_STORE;
            CMD_NAK_FRAME,
            CMD_ACK_FRAME:  state_d = B_ACKS;
            default:        state_d = B_STATUS;
          endcase
        end
      end
      B_STORE:  if (out_free) state_d = B_DELIV;
      B_DELIV:  if (out_free) state_d = deliv_hit ? B_DTIMER : B_ACKS;
      B_DTIMER: if (out_free) state_d = B_DELIV;
      B_ACKS:   if (out_free && !ack_hit) state_d = B_STATUS;
      B_STATUS: if (out_free) state_d = B_IDLE;
      default:  state_d = B_IDLE;
    endcase
  end

  always_comb begin
    cmd_d     = cmd_q;
    oldest_d  = oldest_q;
    next_d    = next_q;
    exp_d     = exp_q;
    rlim_d    = rlim_q;
    out_cnt_d = out_cnt_q;
    nak_ok_d  = nak_ok_q;
    phys_d    = phys_q;
    arrived_d = arrived_q;
    iter_d    = iter_q;
    rec_cnt_d = rec_cnt_q;
    q_pop_o   = 1'b0;
    emit      = 1'b0;
    rec_d     = '0;

    case (state_q)
      B_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o   = 1'b1;
          cmd_d     = q_data_i;
          rec_cnt_d = '0;
        end
      end
      B_MAIN: begin
        if (out_free) begin
          case (cmd_q.cmd)
            CMD_NET: begin
              if (out_cnt_q < CNT_W'(WINDOW_SLOTS)) begin
                emit         = 1'b1;
                rec_d.action = ACT_SEND_DATA;
                rec_d.seq    = next_q;
                rec_d.ack    = last_acked;
                rec_d.slot   = next_q[SLOT_W-1:0];
                rec_d.ticks  = data_ticks_i;
                phys_d       = 1'b0;
                out_cnt_d    = out_cnt_q + 1'b1;
                next_d       = next_q + 1'b1;
              end
            end
            CMD_PHYS: phys_d = 1'b1;
            CMD_BAD_FRAME: begin
              if (nak_ok_q) begin
                emit         = 1'b1;
                rec_d.action = ACT_SEND_NAK;
                rec_d.ack    = last_acked;
                phys_d       = 1'b0;
                nak_ok_d     = 1'b0;
              end
            end
            CMD_DATA_FRAME: begin
              emit = 1'b1;
              if (cmd_q.seq != exp_q && nak_ok_q) begin
                rec_d.action = ACT_SEND_NAK;
                rec_d.ack    = last_acked;
                phys_d       = 1'b0;
                nak_ok_d     = 1'b0;
              end else begin
                rec_d.action = ACT_START_ACK_TIMER;
                rec_d.ticks  = ack_ticks_i;
              end
            end
            CMD_NAK_FRAME: begin
              if (in_window(oldest_q, nak_seq, next_q)) begin
                emit         = 1'b1;
                rec_d.action = ACT_SEND_DATA;
                rec_d.seq    = nak_seq;
                rec_d.ack    = last_acked;
                rec_d.slot   = nak_seq[SLOT_W-1:0];
                rec_d.ticks  = data_ticks_i;
                phys_d       = 1'b0;
              end
            end
            CMD_ACK_TIMEOUT: begin
              emit         = 1'b1;
              rec_d.action = ACT_SEND_ACK;
              rec_d.ack    = last_acked;
              phys_d       = 1'b0;
            end
            CMD_DATA_TIMEOUT: begin
              emit         = 1'b1;
              rec_d.action = ACT_SEND_DATA;
              rec_d.seq    = cmd_q.seq;
              rec_d.ack    = last_acked;
              rec_d.slot   = fslot;
              rec_d.ticks  = data_ticks_i;
              phys_d       = 1'b0;
            end
            default: ;
          endcase
        end
      end
      B_STORE: begin
        if (out_free) begin
          iter_d = '0;
          if (store_hit) begin
            emit             = 1'b1;
            rec_d.action     = ACT_STORE;
            rec_d.seq        = cmd_q.seq;
            rec_d.slot       = fslot;
            arrived_d[fslot] = 1'b1;
          end
        end
      end
      B_DELIV: begin
        if (out_free && deliv_hit) begin
          emit             = 1'b1;
          rec_d.action     = ACT_DELIVER;
          rec_d.seq        = exp_q;
          rec_d.slot       = eslot;
          nak_ok_d         = 1'b1;
          arrived_d[eslot] = 1'b0;
          exp_d            = exp_q + 1'b1;
          rlim_d           = rlim_q + 1'b1;
        end
      end
      B_DTIMER: begin
        if (out_free) begin
          emit         = 1'b1;
          rec_d.action = ACT_START_ACK_TIMER;
          rec_d.ticks  = ack_ticks_i;
          iter_d       = iter_q + 1'b1;
        end
      end
      B_ACKS: begin
        if (out_free && ack_hit) begin
          emit         = 1'b1;
          rec_d.action = ACT_STOP_DATA_TIMER;
          rec_d.seq    = oldest_q;
          out_cnt_d    = out_cnt_q - 1'b1;
          oldest_d     = oldest_q + 1'b1;
        end
      end
      B_STATUS: begin
        if (out_free) begin
          emit         = 1'b1;
          rec_d.action = ACT_STATUS;
          rec_d.en     = (out_cnt_q < CNT_W'(WINDOW_SLOTS)) && phys_q;
          rec_d.last   = 1'b1;
        end
      end
      default: ;
    endcase

    if (load && !rec_d.last) begin
      rec_cnt_d = rec_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      oldest_q    <= '0;
      next_q      <= '0;
      exp_q       <= '0;
      rlim_q      <= SEQ_W'(WINDOW_SLOTS);
      out_cnt_q   <= '0;
      nak_ok_q    <= 1'b1;
      phys_q      <= 1'b0;
      arrived_q   <= '0;
      iter_q      <= '0;
      rec_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      oldest_q  <= oldest_d;
      next_q    <= next_d;
      exp_q     <= exp_d;
      rlim_q    <= rlim_d;
      out_cnt_q <= out_cnt_d;
      nak_ok_q  <= nak_ok_d;
      phys_q    <= phys_d;
      arrived_q <= arrived_d;
      iter_q    <= iter_d;
      rec_cnt_q <= rec_cnt_d;
      if (out_free) begin
        out_valid_q <= load;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    if (out_free && load) begin
      rec_q <= rec_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign rec_o              = rec_q;
  assign stat_o.busy        = (state_q != B_IDLE);
  assign stat_o.outstanding = out_cnt_q;

endmodule

@@ rtl/selective_repeat_arq_control.sv @@
// Selective-repeat ARQ control core, 3-bit sequence numbers, 4-slot windows.
// Each accepted event produces a run of action records ending in one status
// record (last_o set) that carries the network-layer enable. Events enter a
// two-entry queue through a decoder and are executed by a sequencer that
// emits at most one record per cycle into an output register while the
// output is not stalled. An event takes a pop, a decode step and a status
// record; a good frame adds an acknowledgement scan, a data frame also its
// store and delivery steps, and each deliver, start-timer-after-deliver and
// stop-timer record adds a step (at most 15 records per event). The sequencer
// handles one event at a time. Timer durations come from registers 0 (ack
// timer, reset 260) and 1 (data timer, reset 2000), which the user must
// write through the cfg port while idle; the block does not enforce this.
`include "selective_repeat_arq_control_macros.svh"

module selective_repeat_arq_control (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [srarq_pkg::OP_W-1:0]      op_i,
  input  logic                            frame_good_i,
  input  logic [srarq_pkg::KIND_W-1:0]    frame_kind_i,
  input  logic [srarq_pkg::SEQ_W-1:0]     frame_seq_i,
  input  logic [srarq_pkg::SEQ_W-1:0]     peer_ack_i,
  input  logic [srarq_pkg::SEQ_W-1:0]     timeout_seq_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [srarq_pkg::ACT_W-1:0]     action_o,
  output logic [srarq_pkg::SEQ_W-1:0]     seq_out_o,
  output logic [srarq_pkg::SEQ_W-1:0]     ack_out_o,
  output logic [srarq_pkg::SLOT_W-1:0]    slot_o,
  output logic [srarq_pkg::TICK_W-1:0]    timer_ticks_o,
  output logic                            network_enable_o,
  output logic                            last_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [srarq_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [srarq_pkg::TICK_W-1:0]    cfg_data_i
);
  import srarq_pkg::*;

  logic [TICK_W-1:0] ack_ticks_q, ack_ticks_d;
  logic [TICK_W-1:0] data_ticks_q, data_ticks_d;
  logic              q_push, q_full, q_pop, q_empty;
  cmd_t              q_wdata, q_rdata;
  rec_t              rec;
  stat_t             stat;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    ack_ticks_d  = ack_ticks_q;
    data_ticks_d = data_ticks_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ACK_TICKS:  ack_ticks_d  = cfg_data_i;
        CFG_DATA_TICKS: data_ticks_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_ticks_q  <= ACK_TICKS_RST;
      data_ticks_q <= DATA_TICKS_RST;
    end else begin
      ack_ticks_q  <= ack_ticks_d;
      data_ticks_q <= data_ticks_d;
    end
  end

  srarq_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (op_i),
    .frame_good_i  (frame_good_i),
    .frame_kind_i  (frame_kind_i),
    .frame_seq_i   (frame_seq_i),
    .peer_ack_i    (peer_ack_i),
    .timeout_seq_i (timeout_seq_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_data_o      (q_wdata)
  );

  srarq_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  srarq_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_data_i     (q_rdata),
    .q_pop_o      (q_pop),
    .ack_ticks_i  (ack_ticks_q),
    .data_ticks_i (data_ticks_q),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .rec_o        (rec),
    .stat_o       (stat)
  );

  assign action_o         = rec.action;
  assign seq_out_o        = rec.seq;
  assign ack_out_o        = rec.ack;
  assign slot_o           = rec.slot;
  assign timer_ticks_o    = rec.ticks;
  assign network_enable_o = rec.en;
  assign last_o           = rec.last;

  `SRARQ_ASSERT_NOW(a_window_bound, 1'b1, stat.outstanding <= CNT_W'(WINDOW_SLOTS))
  `SRARQ_ASSERT_NOW(a_last_is_status, out_valid_o && last_o, action_o == ACT_STATUS)
  `SRARQ_ASSERT_NOW(a_action_no_enable, out_valid_o && (action_o != ACT_STATUS), !network_enable_o && !last_o)
  `SRARQ_ASSERT_NEXT(a_pop_starts_run, q_pop, stat.busy)

endmodule
